// File: sv/tds_pkg.sv
// tds_pkg: shared types, codes and helpers of the task dependency scoreboard
// no dependencies
`default_nettype none
package tds_pkg;

	localparam int NUM_TASKS = 32;
	localparam int TASK_W    = 5;
	localparam int CNT_W     = 6;
	localparam int INST_W    = 8;
	localparam int PEND_W    = 13;

	localparam logic [2:0] OP_DEFINE   = 3'd0;
	localparam logic [2:0] OP_ADD_DEP  = 3'd1;
	localparam logic [2:0] OP_BUILD    = 3'd2;
	localparam logic [2:0] OP_COMPLETE = 3'd3;
	localparam logic [2:0] OP_QUERY    = 3'd4;

	localparam logic [1:0] STS_OK    = 2'd0;
	localparam logic [1:0] STS_READY = 2'd1;
	localparam logic [1:0] STS_CYCLE = 2'd2;
	localparam logic [1:0] STS_NONE  = 2'd3;

	localparam logic [1:0] MARK_NEW  = 2'd0;
	localparam logic [1:0] MARK_OPEN = 2'd1;
	localparam logic [1:0] MARK_DONE = 2'd2;

	typedef logic [NUM_TASKS-1:0] task_vec_t;

	typedef struct packed {
		logic              found;
		logic [TASK_W-1:0] idx;
	} first_set_t;

	typedef struct packed {
		logic              sum_clear;
		logic              sum_add;
		logic              dec;
		logic              rel_clear;
		logic              rel_set;
		logic [TASK_W-1:0] rel_idx;
		logic              inst_wr;
		logic [TASK_W-1:0] inst_idx;
		logic              inst_nz;
	} lane_ctl_t;

	function automatic first_set_t first_set(input task_vec_t v);
		first_set_t r;
		r.found = 1'b0;
		r.idx   = '0;
		for (int i = NUM_TASKS - 1; i >= 0; i--) begin
			if (v[i]) begin
				r.found = 1'b1;
				r.idx   = TASK_W'(i);
			end
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// File: sv/task_dependency_scoreboard.sv
// task_dependency_scoreboard: top level with sequencer, successor and count memories
// depends on tds_pkg and tds_lanes
//
// One input transaction carries an operation; the block answers with one or
// more result transactions, the final one flagged by last. Both channels use
// valid/stall: a transaction moves at a clock edge with valid high and stall low.
// in_stall is high from acceptance until the last result is loaded.
// Step sequence per operation (output stalls add waits):
//   define_task   one read-modify-write per successor row
//   add_dependency  one successor row read and written
//   complete      one successor row read, its successors' pending counts decremented
//   build         depth-first walk, one step per root, per successor probe,
//                 per row fetch on a push and per pop, then each successor row read and summed
//   query_ready   per reported task a scan, a count memory read and an
//                 output load; a scan and an output load when nothing is ready
// The successor memory (one 32-bit row per task) shapes these sequences.
// Reset clears the successor and instance tables at once through per-row valid bits; no sweep.
// A stalled output holds its result and the sequencer waits for it.
`default_nettype none
module task_dependency_scoreboard (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [2:0] operation,
	input  wire logic [4:0] task_index,
	input  wire logic [4:0] prerequisite_index,
	input  wire logic [7:0] instance_total,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [1:0]      status,
	output logic [4:0]      reported_task,
	output logic [7:0]      reported_instances,
	output logic            last
);

	localparam int NT = tds_pkg::NUM_TASKS;
	localparam int TW = tds_pkg::TASK_W;
	localparam int CW = tds_pkg::CNT_W;
	localparam int IW = tds_pkg::INST_W;
	localparam int SW = TW + CW + NT;

	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_CLR_RD  = 4'd1;
	localparam logic [3:0] S_CLR_WR  = 4'd2;
	localparam logic [3:0] S_ADD_RD  = 4'd3;
	localparam logic [3:0] S_ADD_WR  = 4'd4;
	localparam logic [3:0] S_CMP_RD  = 4'd5;
	localparam logic [3:0] S_CMP_UPD = 4'd6;
	localparam logic [3:0] S_ROOT    = 4'd7;
	localparam logic [3:0] S_FETCH   = 4'd8;
	localparam logic [3:0] S_WALK    = 4'd9;
	localparam logic [3:0] S_POP     = 4'd10;
	localparam logic [3:0] S_SUM_RD  = 4'd11;
	localparam logic [3:0] S_SUM_ACC = 4'd12;
	localparam logic [3:0] S_Q_SCAN  = 4'd13;
	localparam logic [3:0] S_Q_READ  = 4'd14;
	localparam logic [3:0] S_EMIT    = 4'd15;

	// successor rows: bit i of row j set when task i depends on task j
	tds_pkg::task_vec_t succ_mem [NT];
	tds_pkg::task_vec_t succ_vld_q;
	tds_pkg::task_vec_t succ_rd_q;
	logic               succ_rdv_q;
	logic [IW-1:0]      exec_mem [NT];
	tds_pkg::task_vec_t exec_vld_q;
	logic [IW-1:0]      exec_rd_q;
	logic               exec_rdv_q;
	logic [SW-1:0]      stk_mem [NT];
	logic [SW-1:0]      stk_rd_q;

	logic               succ_we, exec_we, stk_we;
	logic [TW-1:0]      succ_raddr, succ_waddr, exec_raddr, exec_waddr;
	logic [TW-1:0]      stk_raddr, stk_waddr;
	tds_pkg::task_vec_t succ_wdata, succ_rdata;
	logic [IW-1:0]      exec_wdata, exec_rdata;
	logic [SW-1:0]      stk_wdata;

	logic [3:0]         state_q, emit_next_q;
	logic [TW-1:0]      task_q, prq_q, top_node_q, q_idx_q;
	logic [CW-1:0]      cnt_q, root_q, sp_q, top_cur_q;
	tds_pkg::task_vec_t top_col_q;
	logic [1:0]         mark_q [NT];
	logic               q_last_q;
	logic [1:0]         res_status_q;
	logic [TW-1:0]      res_task_q;
	logic [IW-1:0]      res_inst_q;
	logic               res_last_q;
	logic               out_valid_q;
	logic [1:0]         out_status_q;
	logic [TW-1:0]      out_task_q;
	logic [IW-1:0]      out_inst_q;
	logic               out_last_q;

	tds_pkg::lane_ctl_t   lctl;
	tds_pkg::task_vec_t   ready;
	tds_pkg::first_set_t  nxt_succ, nxt_ready;
	tds_pkg::task_vec_t   walk_mask;
	logic                 accept, out_free;

	assign accept   = in_valid && !in_stall;
	assign in_stall = state_q != S_IDLE;
	assign out_free = !out_valid_q || !out_stall;

	assign succ_rdata = succ_rdv_q ? succ_rd_q : '0;
	assign exec_rdata = exec_rdv_q ? exec_rd_q : '0;

	assign walk_mask = top_col_q & ({NT{1'b1}} << top_cur_q);
	assign nxt_succ  = tds_pkg::first_set(walk_mask);
	assign nxt_ready = tds_pkg::first_set(ready);

	always_ff @(posedge clk) begin
		if (succ_we) begin
			succ_mem[succ_waddr] <= succ_wdata;
		end
		succ_rd_q <= succ_mem[succ_raddr];
		if (exec_we) begin
			exec_mem[exec_waddr] <= exec_wdata;
		end
		exec_rd_q <= exec_mem[exec_raddr];
		if (stk_we) begin
			stk_mem[stk_waddr] <= stk_wdata;
		end
		stk_rd_q <= stk_mem[stk_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			succ_vld_q <= '0;
			succ_rdv_q <= 1'b0;
			exec_vld_q <= '0;
			exec_rdv_q <= 1'b0;
		end else begin
			if (succ_we) begin
				succ_vld_q[succ_waddr] <= 1'b1;
			end
			if (exec_we) begin
				exec_vld_q[exec_waddr] <= 1'b1;
			end
			succ_rdv_q <= succ_vld_q[succ_raddr];
			exec_rdv_q <= exec_vld_q[exec_raddr];
		end
	end

	always_comb begin
		succ_we    = 1'b0;
		succ_waddr = cnt_q[TW-1:0];
		succ_wdata = succ_rdata;
		succ_raddr = cnt_q[TW-1:0];
		exec_we    = 1'b0;
		exec_waddr = task_index;
		exec_wdata = instance_total;
		exec_raddr = cnt_q[TW-1:0];
		stk_we     = 1'b0;
		stk_waddr  = TW'(sp_q - CW'(1));
		stk_wdata  = {top_node_q, CW'({1'b0, nxt_succ.idx}) + CW'(1), top_col_q};
		stk_raddr  = TW'(sp_q - CW'(2));
		lctl       = '0;
		lctl.rel_idx  = nxt_ready.idx;
		lctl.inst_idx = task_index;
		lctl.inst_nz  = instance_total != '0;
		case (state_q)
			S_IDLE: begin
				if (accept && operation == tds_pkg::OP_DEFINE) begin
					exec_we      = 1'b1;
					lctl.inst_wr = 1'b1;
				end
			end
			S_CLR_WR: begin
				succ_we    = 1'b1;
				succ_wdata = succ_rdata & ~(tds_pkg::task_vec_t'(1) << task_q);
			end
			S_ADD_RD: begin
				succ_raddr = prq_q;
			end
			S_ADD_WR: begin
				succ_we    = 1'b1;
				succ_waddr = prq_q;
				succ_wdata = succ_rdata | (tds_pkg::task_vec_t'(1) << task_q);
			end
			S_CMP_RD: begin
				succ_raddr = task_q;
			end
			S_CMP_UPD: begin
				lctl.dec = 1'b1;
			end
			S_ROOT: begin
				succ_raddr = root_q[TW-1:0];
				if (root_q == CW'(NT)) begin
					lctl.sum_clear = 1'b1;
				end
			end
			S_WALK: begin
				succ_raddr = nxt_succ.idx;
				if (nxt_succ.found && mark_q[nxt_succ.idx] == tds_pkg::MARK_NEW
						&& sp_q < CW'(NT)) begin
					stk_we = 1'b1;
				end
			end
			S_SUM_ACC: begin
				lctl.sum_add = 1'b1;
				if (cnt_q == CW'(NT - 1)) begin
					lctl.rel_clear = 1'b1;
				end
			end
			S_Q_SCAN: begin
				exec_raddr = nxt_ready.idx;
				lctl.rel_set = nxt_ready.found;
			end
			default: begin
			end
		endcase
	end

	tds_lanes u_lanes (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (lctl),
		.col      (succ_rdata),
		.exec_val (exec_rdata),
		.ready    (ready)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_EMIT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			emit_next_q  <= S_IDLE;
			task_q       <= '0;
			prq_q        <= '0;
			cnt_q        <= '0;
			root_q       <= '0;
			sp_q         <= '0;
			top_node_q   <= '0;
			top_cur_q    <= '0;
			top_col_q    <= '0;
			q_idx_q      <= '0;
			q_last_q     <= 1'b0;
			res_status_q <= tds_pkg::STS_OK;
			res_task_q   <= '0;
			res_inst_q   <= '0;
			res_last_q   <= 1'b0;
			out_status_q <= tds_pkg::STS_OK;
			out_task_q   <= '0;
			out_inst_q   <= '0;
			out_last_q   <= 1'b0;
			for (int i = 0; i < NT; i++) begin
				mark_q[i] <= tds_pkg::MARK_NEW;
			end
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						task_q       <= task_index;
						prq_q        <= prerequisite_index;
						cnt_q        <= '0;
						res_status_q <= tds_pkg::STS_OK;
						res_task_q   <= '0;
						res_inst_q   <= '0;
						res_last_q   <= 1'b1;
						emit_next_q  <= S_IDLE;
						case (operation)
							tds_pkg::OP_DEFINE:   state_q <= S_CLR_RD;
							tds_pkg::OP_ADD_DEP:  state_q <= S_ADD_RD;
							tds_pkg::OP_COMPLETE: state_q <= S_CMP_RD;
							tds_pkg::OP_QUERY:    state_q <= S_Q_SCAN;
							tds_pkg::OP_BUILD: begin
								root_q  <= '0;
								state_q <= S_ROOT;
								for (int i = 0; i < NT; i++) begin
									mark_q[i] <= tds_pkg::MARK_NEW;
								end
							end
							default: state_q <= S_EMIT;
						endcase
					end
				end
				S_CLR_RD: begin
					state_q <= S_CLR_WR;
				end
				S_CLR_WR: begin
					cnt_q <= cnt_q + CW'(1);
					if (cnt_q == CW'(NT - 1)) begin
						state_q <= S_EMIT;
					end else begin
						state_q <= S_CLR_RD;
					end
				end
				S_ADD_RD:  state_q <= S_ADD_WR;
				S_ADD_WR:  state_q <= S_EMIT;
				S_CMP_RD:  state_q <= S_CMP_UPD;
				S_CMP_UPD: state_q <= S_EMIT;
				S_ROOT: begin
					if (root_q == CW'(NT)) begin
						cnt_q   <= '0;
						state_q <= S_SUM_RD;
					end else if (mark_q[root_q[TW-1:0]] != tds_pkg::MARK_NEW) begin
						root_q <= root_q + CW'(1);
					end else begin
						top_node_q             <= root_q[TW-1:0];
						top_cur_q              <= '0;
						sp_q                   <= CW'(1);
						mark_q[root_q[TW-1:0]] <= tds_pkg::MARK_OPEN;
						state_q                <= S_FETCH;
					end
				end
				S_FETCH: begin
					top_col_q <= succ_rdata;
					state_q   <= S_WALK;
				end
				S_WALK: begin
					if (!nxt_succ.found) begin
						mark_q[top_node_q] <= tds_pkg::MARK_DONE;
						sp_q               <= sp_q - CW'(1);
						if (sp_q == CW'(1)) begin
							root_q  <= root_q + CW'(1);
							state_q <= S_ROOT;
						end else begin
							state_q <= S_POP;
						end
					end else begin
						top_cur_q <= CW'({1'b0, nxt_succ.idx}) + CW'(1);
						if (mark_q[nxt_succ.idx] == tds_pkg::MARK_OPEN) begin
							res_status_q <= tds_pkg::STS_CYCLE;
							res_task_q   <= nxt_succ.idx;
							state_q      <= S_EMIT;
						end else if (mark_q[nxt_succ.idx] == tds_pkg::MARK_NEW
								&& sp_q < CW'(NT)) begin
							top_node_q           <= nxt_succ.idx;
							top_cur_q            <= '0;
							mark_q[nxt_succ.idx] <= tds_pkg::MARK_OPEN;
							sp_q                 <= sp_q + CW'(1);
							state_q              <= S_FETCH;
						end
					end
				end
				S_POP: begin
					{top_node_q, top_cur_q, top_col_q} <= stk_rd_q;
					state_q <= S_WALK;
				end
				S_SUM_RD: begin
					state_q <= S_SUM_ACC;
				end
				S_SUM_ACC: begin
					cnt_q <= cnt_q + CW'(1);
					if (cnt_q == CW'(NT - 1)) begin
						state_q <= S_EMIT;
					end else begin
						state_q <= S_SUM_RD;
					end
				end
				S_Q_SCAN: begin
					if (!nxt_ready.found) begin
						res_status_q <= tds_pkg::STS_NONE;
						res_last_q   <= 1'b1;
						emit_next_q  <= S_IDLE;
						state_q      <= S_EMIT;
					end else begin
						q_idx_q  <= nxt_ready.idx;
						q_last_q <= (ready & ~(tds_pkg::task_vec_t'(1) << nxt_ready.idx)) == '0;
						state_q  <= S_Q_READ;
					end
				end
				S_Q_READ: begin
					res_status_q <= tds_pkg::STS_READY;
					res_task_q   <= q_idx_q;
					res_inst_q   <= exec_rdata;
					res_last_q   <= q_last_q;
					emit_next_q  <= q_last_q ? S_IDLE : S_Q_SCAN;
					state_q      <= S_EMIT;
				end
				S_EMIT: begin
					if (out_free) begin
						out_status_q <= res_status_q;
						out_task_q   <= res_task_q;
						out_inst_q   <= res_inst_q;
						out_last_q   <= res_last_q;
						state_q      <= emit_next_q;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid          = out_valid_q;
	assign status             = out_status_q;
	assign reported_task      = out_task_q;
	assign reported_instances = out_inst_q;
	assign last               = out_last_q;

`ifndef SYNTHESIS
	a_walk_has_top: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_WALK |-> sp_q != '0)
		else $error("walk with empty stack");
	a_cycle_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == tds_pkg::STS_CYCLE |-> last)
		else $error("cycle report not final");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("block idle after accepting a transaction");
	a_ready_has_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == tds_pkg::STS_READY |-> reported_instances != '0)
		else $error("ready task reported with no instances");
`endif

endmodule
`default_nettype wire

// File: sv/tds_lanes.sv
// tds_lanes: per-task pending counts, released flags and instance flags
// depends on tds_pkg
`default_nettype none
module tds_lanes (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire tds_pkg::lane_ctl_t            ctl,
	input  wire tds_pkg::task_vec_t            col,
	input  wire logic [tds_pkg::INST_W-1:0]    exec_val,
	output tds_pkg::task_vec_t                 ready
);

	logic [tds_pkg::PEND_W-1:0] pending_q [tds_pkg::NUM_TASKS];
	tds_pkg::task_vec_t         released_q;
	tds_pkg::task_vec_t         has_inst_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < tds_pkg::NUM_TASKS; i++) begin
				pending_q[i] <= '0;
			end
			released_q <= '0;
			has_inst_q <= '0;
		end else begin
			for (int i = 0; i < tds_pkg::NUM_TASKS; i++) begin
				if (ctl.sum_clear) begin
					pending_q[i] <= '0;
				end else if (ctl.sum_add && col[i]) begin
					pending_q[i] <= pending_q[i] +
						{{(tds_pkg::PEND_W-tds_pkg::INST_W){1'b0}}, exec_val};
				end else if (ctl.dec && col[i] && pending_q[i] != '0) begin
					pending_q[i] <= pending_q[i] - tds_pkg::PEND_W'(1);
				end
			end
			if (ctl.rel_clear) begin
				released_q <= '0;
			end else if (ctl.rel_set) begin
				released_q[ctl.rel_idx] <= 1'b1;
			end
			if (ctl.inst_wr) begin
				has_inst_q[ctl.inst_idx] <= ctl.inst_nz;
			end
		end
	end

	always_comb begin
		for (int i = 0; i < tds_pkg::NUM_TASKS; i++) begin
			ready[i] = !released_q[i] && pending_q[i] == '0 && has_inst_q[i];
		end
	end

endmodule
`default_nettype wire
